// ===== design/sirt_pkg.sv =====
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types and constants of the session id rendezvous table.
// ----------------------------------------------------------------------------
package sirt_pkg;

  localparam int ID_BITS_DEFAULT     = 6;
  localparam int HANDLE_BITS_DEFAULT = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  localparam logic [0:0] REG_ALLOC_MODE = 1'b0;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_SEND  = 2'd1,
    OP_RECV  = 2'd2,
    OP_CLOSE = 2'd3
  } op_e;

endpackage

// ===== design/sirt_if.sv =====
// ----------------------------------------------------------------------------
// sirt_if
// Request and response channels of the session id rendezvous table.
// ----------------------------------------------------------------------------
interface sirt_req_if #(
  parameter int ID_BITS     = sirt_pkg::ID_BITS_DEFAULT,
  parameter int HANDLE_BITS = sirt_pkg::HANDLE_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             operation;
  logic [ID_BITS-1:0]     session_id;
  logic [HANDLE_BITS-1:0] message_handle;
  logic [HANDLE_BITS-1:0] waiter_handle;
  logic                   discard;

  modport source (
    output valid, operation, session_id, message_handle, waiter_handle, discard,
    input  ready
  );
  modport sink (
    input  valid, operation, session_id, message_handle, waiter_handle, discard,
    output ready
  );
endinterface

interface sirt_rsp_if #(
  parameter int ID_BITS     = sirt_pkg::ID_BITS_DEFAULT,
  parameter int HANDLE_BITS = sirt_pkg::HANDLE_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic                   status;
  logic [ID_BITS-1:0]     allocated_id;
  logic                   delivered;
  logic [HANDLE_BITS-1:0] delivered_message;
  logic [HANDLE_BITS-1:0] delivered_waiter;
  logic                   delivered_discard;

  modport source (
    output valid, status, allocated_id, delivered, delivered_message,
           delivered_waiter, delivered_discard,
    input  ready
  );
  modport sink (
    input  valid, status, allocated_id, delivered, delivered_message,
           delivered_waiter, delivered_discard,
    output ready
  );
endinterface

// ===== design/sirt_ram.sv =====
// ----------------------------------------------------------------------------
// sirt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sirt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sirt_front.sv =====
// ----------------------------------------------------------------------------
// sirt_front
// Accepts request words, decodes the operation and queues them for the
// back end.
// ----------------------------------------------------------------------------
module sirt_front #(
  parameter int ID_BITS     = sirt_pkg::ID_BITS_DEFAULT,
  parameter int HANDLE_BITS = sirt_pkg::HANDLE_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sirt_req_if.sink               req_i,
  output logic                   q_valid_o,
  input  logic                   q_pop_i,
  output sirt_pkg::op_e          q_op_o,
  output logic [ID_BITS-1:0]     q_id_o,
  output logic [HANDLE_BITS-1:0] q_msg_o,
  output logic [HANDLE_BITS-1:0] q_wait_o,
  output logic                   q_disc_o
);

  localparam int ItemBits = 2 + ID_BITS + 2 * HANDLE_BITS + 1;

  logic [ItemBits-1:0]            fifo_q [sirt_pkg::QUEUE_DEPTH];
  logic [sirt_pkg::QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [sirt_pkg::QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [sirt_pkg::QPTR_BITS:0]   count_q, count_d;
  logic                           push;
  logic                           pop;
  logic [ItemBits-1:0]            head;

  assign req_i.ready = (count_q != (sirt_pkg::QPTR_BITS+1)'(sirt_pkg::QUEUE_DEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign q_valid_o   = (count_q != '0);
  assign pop         = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == sirt_pkg::QPTR_BITS'(sirt_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == sirt_pkg::QPTR_BITS'(sirt_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= {req_i.operation, req_i.session_id, req_i.message_handle,
                           req_i.waiter_handle, req_i.discard};
    end
  end

  assign head     = fifo_q[rd_ptr_q];
  assign q_op_o   = sirt_pkg::op_e'(head[ItemBits-1 -: 2]);
  assign q_id_o   = head[2*HANDLE_BITS+1 +: ID_BITS];
  assign q_msg_o  = head[HANDLE_BITS+1 +: HANDLE_BITS];
  assign q_wait_o = head[1 +: HANDLE_BITS];
  assign q_disc_o = head[0];

endmodule

// ===== design/sirt_back.sv =====
// ----------------------------------------------------------------------------
// sirt_back
// Executes queued operations against the session table and registers the
// response word.
// ----------------------------------------------------------------------------
module sirt_back #(
  parameter int ID_BITS     = sirt_pkg::ID_BITS_DEFAULT,
  parameter int HANDLE_BITS = sirt_pkg::HANDLE_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   alloc_mode_i,
  input  logic                   q_valid_i,
  output logic                   q_pop_o,
  input  sirt_pkg::op_e          q_op_i,
  input  logic [ID_BITS-1:0]     q_id_i,
  input  logic [HANDLE_BITS-1:0] q_msg_i,
  input  logic [HANDLE_BITS-1:0] q_wait_i,
  input  logic                   q_disc_i,
  sirt_rsp_if.source             rsp_o
);

  localparam int TableSize = 1 << ID_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                   state_q, state_d;
  logic [TableSize-1:0]   present_q, present_d;
  logic [TableSize-1:0]   hmsg_q, hmsg_d;
  logic [TableSize-1:0]   hwait_q, hwait_d;
  logic [ID_BITS-1:0]     seq_q, seq_d;

  sirt_pkg::op_e          op_q;
  logic [ID_BITS-1:0]     id_q;
  logic [HANDLE_BITS-1:0] msg_q;
  logic [HANDLE_BITS-1:0] wait_q;
  logic                   disc_q;

  logic                   out_valid_q, out_valid_d;
  logic                   status_q, status_d;
  logic [ID_BITS-1:0]     alloc_q, alloc_d;
  logic                   dlv_q, dlv_d;
  logic [HANDLE_BITS-1:0] dmsg_q, dmsg_d;
  logic [HANDLE_BITS-1:0] dwait_q, dwait_d;
  logic                   ddisc_q, ddisc_d;

  logic                   out_free;
  logic                   pop;
  logic [ID_BITS-1:0]     free_idx;
  logic                   full;
  logic                   hit_p, hit_m, hit_w;
  logic                   msg_we, wait_we;
  logic [HANDLE_BITS-1:0] msg_rdata;
  logic [HANDLE_BITS:0]   wait_rdata;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign pop      = (state_q == ST_IDLE) && q_valid_i && out_free;
  assign q_pop_o  = pop;

  always_comb begin
    free_idx = '0;
    for (int i = TableSize - 1; i >= 0; i--) begin
      if (!present_q[i]) begin
        free_idx = ID_BITS'(i);
      end
    end
  end

  assign full  = &present_q;
  assign hit_p = present_q[id_q];
  assign hit_m = hmsg_q[id_q];
  assign hit_w = hwait_q[id_q];

  assign msg_we  = (state_q == ST_EXEC) && (op_q == sirt_pkg::OP_SEND) && !(hit_p && hit_w);
  assign wait_we = (state_q == ST_EXEC) && (op_q == sirt_pkg::OP_RECV) && !(hit_p && hit_m);

  sirt_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (TableSize)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (msg_we),
    .waddr_i (id_q),
    .wdata_i (msg_q),
    .re_i    (pop),
    .raddr_i (q_id_i),
    .rdata_o (msg_rdata)
  );

  sirt_ram #(
    .WIDTH (HANDLE_BITS + 1),
    .DEPTH (TableSize)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (wait_we),
    .waddr_i (id_q),
    .wdata_i ({disc_q, wait_q}),
    .re_i    (pop),
    .raddr_i (q_id_i),
    .rdata_o (wait_rdata)
  );

  always_comb begin
    state_d     = state_q;
    present_d   = present_q;
    hmsg_d      = hmsg_q;
    hwait_d     = hwait_q;
    seq_d       = seq_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    status_d    = status_q;
    alloc_d     = alloc_q;
    dlv_d       = dlv_q;
    dmsg_d      = dmsg_q;
    dwait_d     = dwait_q;
    ddisc_d     = ddisc_q;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        status_d    = 1'b0;
        alloc_d     = '0;
        dlv_d       = 1'b0;
        dmsg_d      = '0;
        dwait_d     = '0;
        ddisc_d     = 1'b0;
        case (op_q)
          sirt_pkg::OP_ALLOC: begin
            if (alloc_mode_i) begin
              alloc_d = seq_q;
              seq_d   = seq_q + 1'b1;
            end else if (full) begin
              status_d = 1'b1;
            end else begin
              alloc_d             = free_idx;
              present_d[free_idx] = 1'b1;
              hmsg_d[free_idx]    = 1'b0;
              hwait_d[free_idx]   = 1'b0;
            end
          end
          sirt_pkg::OP_SEND: begin
            if (hit_p && hit_w) begin
              dlv_d          = 1'b1;
              dmsg_d         = msg_q;
              dwait_d        = wait_rdata[HANDLE_BITS-1:0];
              ddisc_d        = wait_rdata[HANDLE_BITS];
              present_d[id_q] = 1'b0;
              hmsg_d[id_q]    = 1'b0;
              hwait_d[id_q]   = 1'b0;
            end else begin
              present_d[id_q] = 1'b1;
              hmsg_d[id_q]    = 1'b1;
            end
          end
          sirt_pkg::OP_RECV: begin
            if (hit_p && hit_m) begin
              dlv_d          = 1'b1;
              dmsg_d         = msg_rdata;
              dwait_d        = wait_q;
              ddisc_d        = disc_q;
              present_d[id_q] = 1'b0;
              hmsg_d[id_q]    = 1'b0;
              hwait_d[id_q]   = 1'b0;
            end else begin
              present_d[id_q] = 1'b1;
              hwait_d[id_q]   = 1'b1;
            end
          end
          default: begin
            present_d[id_q] = 1'b0;
            hmsg_d[id_q]    = 1'b0;
            hwait_d[id_q]   = 1'b0;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      present_q   <= '0;
      hmsg_q      <= '0;
      hwait_q     <= '0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      hmsg_q      <= hmsg_d;
      hwait_q     <= hwait_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      op_q   <= q_op_i;
      id_q   <= q_id_i;
      msg_q  <= q_msg_i;
      wait_q <= q_wait_i;
      disc_q <= q_disc_i;
    end
    status_q <= status_d;
    alloc_q  <= alloc_d;
    dlv_q    <= dlv_d;
    dmsg_q   <= dmsg_d;
    dwait_q  <= dwait_d;
    ddisc_q  <= ddisc_d;
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.status            = status_q;
  assign rsp_o.allocated_id      = alloc_q;
  assign rsp_o.delivered         = dlv_q;
  assign rsp_o.delivered_message = dmsg_q;
  assign rsp_o.delivered_waiter  = dwait_q;
  assign rsp_o.delivered_discard = ddisc_q;

endmodule

// ===== design/session_id_rendezvous_table_top.sv =====
// ----------------------------------------------------------------------------
// session_id_rendezvous_table_top
// Session table indexed by id: allocate, send/receive rendezvous, close.
// ----------------------------------------------------------------------------
// Every request word returns exactly one response word, in order. A two-entry
// queue takes requests; the execute stage takes each through IDLE (pop starts
// the handle RAM read) and EXEC (table update, response register), popping no
// new one until back in IDLE with the output free. The lowest free id comes
// from a priority encoder over the presence bits. The table is empty right out
// of reset, with no clearing pass. Register 0 at byte address 0, bit 0,
// selects sequential id allocation; write it only while the block is idle.
module session_id_rendezvous_table_top #(
  parameter int ID_BITS     = sirt_pkg::ID_BITS_DEFAULT,
  parameter int HANDLE_BITS = sirt_pkg::HANDLE_BITS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sirt_req_if.sink                        req_i,
  sirt_rsp_if.source                      rsp_o,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [sirt_pkg::PADDR_BITS-1:0] paddr_i,
  input  logic [sirt_pkg::PDATA_BITS-1:0] pwdata_i,
  output logic [sirt_pkg::PDATA_BITS-1:0] prdata_o,
  output logic                            pready_o
);

  logic                   mode_q;
  logic                   reg_sel;
  logic                   q_valid;
  logic                   q_pop;
  sirt_pkg::op_e          q_op;
  logic [ID_BITS-1:0]     q_id;
  logic [HANDLE_BITS-1:0] q_msg;
  logic [HANDLE_BITS-1:0] q_wait;
  logic                   q_disc;

  assign pready_o = 1'b1;
  assign reg_sel  = (paddr_i[sirt_pkg::PADDR_BITS-1] == sirt_pkg::REG_ALLOC_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i && pready_o && reg_sel) begin
      mode_q <= pwdata_i[0];
    end
  end

  assign prdata_o = reg_sel ? {{(sirt_pkg::PDATA_BITS-1){1'b0}}, mode_q} : '0;

  sirt_front #(
    .ID_BITS     (ID_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_op_o    (q_op),
    .q_id_o    (q_id),
    .q_msg_o   (q_msg),
    .q_wait_o  (q_wait),
    .q_disc_o  (q_disc)
  );

  sirt_back #(
    .ID_BITS     (ID_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .alloc_mode_i (mode_q),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_op_i       (q_op),
    .q_id_i       (q_id),
    .q_msg_i      (q_msg),
    .q_wait_i     (q_wait),
    .q_disc_i     (q_disc),
    .rsp_o        (rsp_o)
  );

endmodule
